// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of the ease curve block.
// Needs nothing else; every macro reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

// ===== sv/ece_pkg.sv =====
// Shared types, constants and the rounding multiplier of the ease curve block.
// No dependencies; every file but the assertion macros refers to it by scoped names.
`default_nettype none

package ece_pkg;

  localparam int TIME_W  = 17;
  localparam int EASE_W  = 17;
  localparam int IN_FRAC = 16;
  localparam int MUL_W   = 31;

  localparam logic [EASE_W-1:0] IN_ONE = 17'h10000;

  // How an item is resolved: by the curve, or directly at either end.
  typedef enum logic [1:0] {
    EC_SOLVE,
    EC_ZERO,
    EC_ONE
  } ece_class_t;

  typedef struct packed {
    logic       valid;
    ece_class_t cls;
  } ece_ctrl_t;

  // Fixed-point product with fb fraction bits, rounded half up.
  function automatic logic [MUL_W-1:0] fx_mul(input logic [MUL_W-1:0] x,
                                              input logic [MUL_W-1:0] y,
                                              input int unsigned      fb);
    logic [2*MUL_W-1:0] p;
    p = (2*MUL_W)'(x) * (2*MUL_W)'(y);
    p = p + ((2*MUL_W)'(1) << (fb - 1));
    return MUL_W'(p >> fb);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ece_time_if.sv =====
// Input channel of the ease curve block: valid/ready plus one time value.
// Depends on ece_pkg for the field width.
`default_nettype none

interface ece_time_if;
  logic                         valid;
  logic                         ready;
  logic [ece_pkg::TIME_W-1:0]   time_in;

  modport source (output valid, output time_in, input ready);
  modport sink   (input valid, input time_in, output ready);
endinterface

`default_nettype wire

// ===== sv/ece_ease_if.sv =====
// Output channel of the ease curve block: valid/ready plus one eased value.
// Depends on ece_pkg for the field width.
`default_nettype none

interface ece_ease_if;
  logic                         valid;
  logic                         ready;
  logic [ece_pkg::EASE_W-1:0]   eased_out;

  modport source (output valid, output eased_out, input ready);
  modport sink   (input valid, input eased_out, output ready);
endinterface

`default_nettype wire

// ===== sv/css_ease_curve_top.sv =====
// Top level of the ease curve block: input stage, bisection cells, y stage
// and output skid. Depends on ece_pkg, both channel interfaces and all cells.
//
//   channel   dir   handshake     payload
//   time_ch   in    valid/ready   time_in   17 b unsigned Q1.16
//   ease_ch   out   valid/ready   eased_out 17 b unsigned Q1.16
//
// One item per cycle sustained while the output is not stalled; each result passes
// through the input stage, the cells, the y stage and the output skid in order.
// The row of cells does one bisection step per cell, four register stages
// each (midpoint, squares, cubic terms, compare).
// Reset clears only the control fields (valid bits and classes); no clearing pass.
// A stalled output fills the spare slot, then the whole pipeline holds;
// ready comes straight from a register.
`default_nettype none

module css_ease_curve_top #(
  parameter int BISECT_STEPS = 24,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  ece_time_if.sink    time_ch,
  ece_ease_if.source  ease_ch
);

  localparam int W  = FRAC_BITS + 1;
  localparam int UP = (FRAC_BITS >= ece_pkg::IN_FRAC) ? FRAC_BITS - ece_pkg::IN_FRAC : 0;
  localparam int DN = (FRAC_BITS < ece_pkg::IN_FRAC) ? ece_pkg::IN_FRAC - FRAC_BITS : 0;
  localparam int TW = ece_pkg::IN_FRAC + UP;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic                        adv;
  ece_pkg::ece_ctrl_t          ctl0;
  ece_pkg::ece_class_t         cls_next;
  logic [FRAC_BITS-1:0]        t0;

  ece_pkg::ece_ctrl_t          ctl_c [BISECT_STEPS+1];
  logic [FRAC_BITS-1:0]        t_c   [BISECT_STEPS+1];
  logic [W-1:0]                lo_c  [BISECT_STEPS+1];
  logic [W-1:0]                hi_c  [BISECT_STEPS+1];
  logic [W-1:0]                u_c   [BISECT_STEPS];
  logic [W-1:0]                v_c   [BISECT_STEPS];

  logic                        y_valid;
  logic [ece_pkg::EASE_W-1:0]  y_eased;

  assign time_ch.ready = adv;

  always_comb begin
    if (time_ch.time_in == '0) begin
      cls_next = ece_pkg::EC_ZERO;
    end else if (time_ch.time_in >= ece_pkg::IN_ONE) begin
      cls_next = ece_pkg::EC_ONE;
    end else begin
      cls_next = ece_pkg::EC_SOLVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else if (adv) begin
      ctl0.valid <= time_ch.valid;
      ctl0.cls   <= cls_next;
    end
  end

  // move the time into the internal format
  always_ff @(posedge clk) begin
    if (adv) begin
      t0 <= FRAC_BITS'((TW'(time_ch.time_in[ece_pkg::IN_FRAC-1:0]) << UP) >> DN);
    end
  end

  assign ctl_c[0] = ctl0;
  assign t_c[0]   = t0;
  assign lo_c[0]  = '0;
  assign hi_c[0]  = ONE;

  for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_cell
    ece_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .ctl_i (ctl_c[i]),
      .t_i   (t_c[i]),
      .lo_i  (lo_c[i]),
      .hi_i  (hi_c[i]),
      .ctl_o (ctl_c[i+1]),
      .t_o   (t_c[i+1]),
      .lo_o  (lo_c[i+1]),
      .hi_o  (hi_c[i+1]),
      .u_o   (u_c[i]),
      .v_o   (v_c[i])
    );
  end

  ece_yeval #(
    .FRAC_BITS (FRAC_BITS)
  ) u_yeval (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .ctl_i   (ctl_c[BISECT_STEPS]),
    .u_i     (u_c[BISECT_STEPS-1]),
    .v_i     (v_c[BISECT_STEPS-1]),
    .valid_o (y_valid),
    .eased_o (y_eased)
  );

  ece_skid u_skid (
    .clk     (clk),
    .rst     (rst),
    .push    (adv && y_valid),
    .data    (y_eased),
    .room    (adv),
    .ease_ch (ease_ch)
  );

endmodule

`default_nettype wire

// ===== sv/ece_cell.sv =====
// One bisection step on the x polynomial, four register stages deep.
// Depends on ece_pkg (control struct, rounding multiplier).
`default_nettype none

module ece_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  ece_pkg::ece_ctrl_t    ctl_i,
  input  logic [FRAC_BITS-1:0]  t_i,
  input  logic [FRAC_BITS:0]    lo_i,
  input  logic [FRAC_BITS:0]    hi_i,
  output ece_pkg::ece_ctrl_t    ctl_o,
  output logic [FRAC_BITS-1:0]  t_o,
  output logic [FRAC_BITS:0]    lo_o,
  output logic [FRAC_BITS:0]    hi_o,
  output logic [FRAC_BITS:0]    u_o,
  output logic [FRAC_BITS:0]    v_o
);

  localparam int W  = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 3;
  localparam int MW = ece_pkg::MUL_W;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  ece_pkg::ece_ctrl_t   c1, c2, c3;
  logic [FRAC_BITS-1:0] t1, t2, t3;
  logic [W-1:0]         lo1, lo2, lo3;
  logic [W-1:0]         hi1, hi2, hi3;
  logic [W-1:0]         u1, u2, u3;
  logic [W-1:0]         v1, v2, v3;
  logic [W-1:0]         vv2, uu2;
  logic [W-1:0]         p1, p2, p3;

  logic [W:0]           sum;
  logic [W-1:0]         mid;
  logic [PW-1:0]        q1, q2, px;
  logic                 below;

  always_comb begin
    sum   = (W+1)'(lo_i) + (W+1)'(hi_i);
    mid   = sum[W:1];
    // multiply by a quarter: (p + 2) >> 2 is the rounded product
    q1    = (PW'(p1) + PW'(2)) >> 2;
    q2    = (PW'(p2) + PW'(2)) >> 2;
    px    = PW'(3) * q1 + PW'(3) * q2 + PW'(p3);
    below = px < PW'(t3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1    <= '0;
      c2    <= '0;
      c3    <= '0;
      ctl_o <= '0;
    end else if (adv) begin
      c1    <= ctl_i;
      c2    <= c1;
      c3    <= c2;
      ctl_o <= c3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // midpoint and its complement
      t1  <= t_i;
      lo1 <= lo_i;
      hi1 <= hi_i;
      u1  <= mid;
      v1  <= ONE - mid;
      // squares
      t2  <= t1;
      lo2 <= lo1;
      hi2 <= hi1;
      u2  <= u1;
      v2  <= v1;
      vv2 <= W'(ece_pkg::fx_mul(MW'(v1), MW'(v1), FRAC_BITS));
      uu2 <= W'(ece_pkg::fx_mul(MW'(u1), MW'(u1), FRAC_BITS));
      // cubic terms
      t3  <= t2;
      lo3 <= lo2;
      hi3 <= hi2;
      u3  <= u2;
      v3  <= v2;
      p1  <= W'(ece_pkg::fx_mul(MW'(vv2), MW'(u2), FRAC_BITS));
      p2  <= W'(ece_pkg::fx_mul(MW'(v2), MW'(uu2), FRAC_BITS));
      p3  <= W'(ece_pkg::fx_mul(MW'(uu2), MW'(u2), FRAC_BITS));
      // narrow the bracket
      t_o  <= t3;
      u_o  <= u3;
      v_o  <= v3;
      lo_o <= below ? u3 : lo3;
      hi_o <= below ? hi3 : u3;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ece_yeval.sv =====
// Evaluates the y polynomial at the solved parameter and forms the result.
// Five register stages; depends on ece_pkg.
`default_nettype none

module ece_yeval #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  ece_pkg::ece_ctrl_t           ctl_i,
  input  logic [FRAC_BITS:0]           u_i,
  input  logic [FRAC_BITS:0]           v_i,
  output logic                         valid_o,
  output logic [ece_pkg::EASE_W-1:0]   eased_o
);

  localparam int W   = FRAC_BITS + 1;
  localparam int PW  = FRAC_BITS + 3;
  localparam int MW  = ece_pkg::MUL_W;
  localparam int UP  = (FRAC_BITS >= ece_pkg::IN_FRAC) ? FRAC_BITS - ece_pkg::IN_FRAC : 0;
  localparam int DN  = (FRAC_BITS < ece_pkg::IN_FRAC) ? ece_pkg::IN_FRAC - FRAC_BITS : 0;
  localparam int RW  = FRAC_BITS + 4 + DN;
  localparam int RND = (1 << UP) >> 1;
  localparam logic [W-1:0] TENTH = W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  ece_pkg::ece_ctrl_t c1, c2, c3, c4;
  logic [W-1:0]       u1, v1, vv1, uu1;
  logic [W-1:0]       p1, p2, p3;
  logic [W-1:0]       q3, p2_3, p3_3;
  logic [PW-1:0]      y4;

  logic [RW-1:0]               conv;
  logic [ece_pkg::EASE_W-1:0]  sat;
  logic [ece_pkg::EASE_W-1:0]  eased_next;

  always_comb begin
    conv = ((RW'(y4) + RW'(RND)) >> UP) << DN;
    sat  = (conv > RW'(ece_pkg::IN_ONE)) ? ece_pkg::IN_ONE : ece_pkg::EASE_W'(conv);
    unique case (c4.cls)
      ece_pkg::EC_SOLVE: eased_next = sat;
      ece_pkg::EC_ONE:   eased_next = ece_pkg::IN_ONE;
      ece_pkg::EC_ZERO:  eased_next = '0;
      default:           eased_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1      <= '0;
      c2      <= '0;
      c3      <= '0;
      c4      <= '0;
      valid_o <= 1'b0;
    end else if (adv) begin
      c1      <= ctl_i;
      c2      <= c1;
      c3      <= c2;
      c4      <= c3;
      valid_o <= c4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1   <= u_i;
      v1   <= v_i;
      vv1  <= W'(ece_pkg::fx_mul(MW'(v_i), MW'(v_i), FRAC_BITS));
      uu1  <= W'(ece_pkg::fx_mul(MW'(u_i), MW'(u_i), FRAC_BITS));
      p1   <= W'(ece_pkg::fx_mul(MW'(vv1), MW'(u1), FRAC_BITS));
      p2   <= W'(ece_pkg::fx_mul(MW'(v1), MW'(uu1), FRAC_BITS));
      p3   <= W'(ece_pkg::fx_mul(MW'(uu1), MW'(u1), FRAC_BITS));
      // the second control point has y = 1, so that product is p2 itself
      q3   <= W'(ece_pkg::fx_mul(MW'(p1), MW'(TENTH), FRAC_BITS));
      p2_3 <= p2;
      p3_3 <= p3;
      y4   <= PW'(3) * PW'(q3) + PW'(3) * PW'(p2_3) + PW'(p3_3);
      eased_o <= eased_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ece_skid.sv =====
// Output register with a spare slot, so the pipeline keeps moving after the
// consumer stalls until the spare fills. Depends on ece_pkg and ece_ease_if.
`default_nettype none

module ece_skid (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [ece_pkg::EASE_W-1:0]   data,
  output logic                         room,
  ece_ease_if.source                   ease_ch
);

  logic                        out_valid;
  logic [ece_pkg::EASE_W-1:0]  out_data;
  logic                        spare_valid;
  logic [ece_pkg::EASE_W-1:0]  spare_data;
  logic                        pop;

  assign pop               = out_valid && ease_ch.ready;
  assign room              = !spare_valid;
  assign ease_ch.valid     = out_valid;
  assign ease_ch.eased_out = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      // drain the spare first; nothing is pushed meanwhile
      if (pop) begin
        out_data    <= spare_data;
        spare_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
      out_data  <= data;
    end else if (push) begin
      spare_valid <= 1'b1;
      spare_data  <= data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ece_checker.sv =====
// Port-level checks of the ease curve block, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ece_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [ece_pkg::TIME_W-1:0]   time_in,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ece_pkg::EASE_W-1:0]   eased_out
);

  logic in_take;

  assign in_take = in_valid && in_ready && (time_in == '0);

  // a waiting result stays put until taken
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(eased_out))

  // nothing leaves straight after reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !out_valid)

  // with no result waiting, the input side is always open
  `ASSERT_IMPLY(a_ready_free, clk, rst, !out_valid, in_ready || in_take)

  // ready only drops after a result was held back
  `ASSERT_IMPLY(a_ready_drop, clk, rst, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind css_ease_curve_top ece_checker u_ece_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (time_ch.valid),
  .in_ready  (time_ch.ready),
  .time_in   (time_ch.time_in),
  .out_valid (ease_ch.valid),
  .out_ready (ease_ch.ready),
  .eased_out (ease_ch.eased_out)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for css_ease_curve_top: directed end points and corners, then random time values.
// Uses ece_pkg and both channel interfaces; an internal model predicts each eased value.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CURVE_FB     = 16;
  localparam int CURVE_STEPS  = 24;
  localparam int PIPE_CYCLES  = 4 * CURVE_STEPS + 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ece_time_if time_ch ();
  ece_ease_if ease_ch ();

  css_ease_curve_top #(
    .BISECT_STEPS(CURVE_STEPS),
    .FRAC_BITS   (CURVE_FB)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .time_ch(time_ch),
    .ease_ch(ease_ch)
  );

  logic [ece_pkg::EASE_W-1:0] eased_due_q[$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  logic              no_idle = 1'b0;
  logic              hold_req = 1'b0;
  int                hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Curve model: fixed-point cubic bezier, x solved by bisection, then y.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] qmul(input logic [63:0] x, input logic [63:0] y);
    return (x * y + (64'd1 << (CURVE_FB - 1))) >> CURVE_FB;
  endfunction

  function automatic logic [63:0] bezier_at(input logic [63:0] u, input logic [63:0] a,
                                            input logic [63:0] b);
    logic [63:0] one_q;
    logic [63:0] v;
    logic [63:0] vv;
    logic [63:0] uu;
    one_q = 64'd1 << CURVE_FB;
    v  = (u <= one_q) ? one_q - u : 64'd0;
    vv = qmul(v, v);
    uu = qmul(u, u);
    return 64'd3 * qmul(qmul(vv, u), a) + 64'd3 * qmul(qmul(v, uu), b) + qmul(uu, u);
  endfunction

  function automatic logic [ece_pkg::EASE_W-1:0] ease_curve_value(
      input logic [ece_pkg::TIME_W-1:0] t_in);
    logic [63:0] one_q;
    logic [63:0] t;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] u;
    logic [63:0] y;
    logic [63:0] r;
    int          up;
    int          dn;
    one_q = 64'd1 << CURVE_FB;
    if (t_in == '0) return '0;
    if (t_in >= ece_pkg::IN_ONE) return ece_pkg::IN_ONE;
    up = (CURVE_FB >= 16) ? CURVE_FB - 16 : 0;
    dn = (CURVE_FB < 16) ? 16 - CURVE_FB : 0;
    t  = (64'(t_in) << up) >> dn;
    lo = '0;
    hi = one_q;
    u  = t;
    for (int i = 0; i < CURVE_STEPS; i++) begin
      u = (lo + hi) >> 1;
      if (bezier_at(u, one_q >> 2, one_q >> 2) < t) lo = u;
      else hi = u;
    end
    y = bezier_at(u, (one_q + 64'd5) / 64'd10, one_q);
    if (up > 0) r = (y + (64'd1 << (up - 1))) >> up;
    else r = y << dn;
    if (r > 64'(ece_pkg::IN_ONE)) r = 64'(ece_pkg::IN_ONE);
    return r[ece_pkg::EASE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the item until it is taken.
  // ---------------------------------------------------------------------------
  task automatic send_time(input logic [ece_pkg::TIME_W-1:0] t);
    while (!no_idle && $urandom_range(99) < 12) begin
      time_ch.valid <= 1'b0;
      @(posedge clk);
    end
    time_ch.valid   <= 1'b1;
    time_ch.time_in <= t;
    @(posedge clk);
    while (!time_ch.ready) @(posedge clk);
    eased_due_q = {eased_due_q, ease_curve_value(t)};
  endtask

  function automatic logic [ece_pkg::TIME_W-1:0] random_time();
    int pick;
    pick = $urandom_range(99);
    if (pick < 78) return ece_pkg::TIME_W'($urandom_range(65535, 1));
    if (pick < 86) return ece_pkg::TIME_W'($urandom_range(131071, 65536));
    if (pick < 90) return '0;
    if (pick < 95) return ece_pkg::TIME_W'($urandom_range(255, 1));
    return ece_pkg::TIME_W'($urandom);
  endfunction

  // Receiver: random stalls, a clean stretch on request, and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      ease_ch.ready <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
      ease_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      ease_ch.ready <= 1'b0;
    end else if (no_idle) begin
      ease_ch.ready <= 1'b1;
    end else begin
      ease_ch.ready <= ($urandom_range(99) >= 12);
    end
  end

  // Checker: each result against the oldest pending prediction.
  always @(posedge clk) begin : check_results
    logic [ece_pkg::EASE_W-1:0] want;
    if (!rst && ease_ch.valid && ease_ch.ready) begin
      if (eased_due_q.size() == 0) begin
        $error("eased_out: unexpected result %0d", ease_ch.eased_out);
        mismatch_count++;
      end else begin
        want = eased_due_q.pop_front();
        if (ease_ch.eased_out !== want) begin
          $error("eased_out: expected %0d, actual %0d", want, ease_ch.eased_out);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic reset_block();
    time_ch.valid   <= 1'b0;
    time_ch.time_in <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Zero, exactly one, and values above one that must clamp.
  task automatic test_end_points();
    logic [ece_pkg::TIME_W-1:0] ends[$];
    ends = '{17'h00000, 17'h10000, 17'h10001, 17'h18000, 17'h15555, 17'h1FFFF, 17'h00000};
    foreach (ends[i]) send_time(ends[i]);
  endtask

  // Smallest and largest solvable times and some bit patterns in between.
  task automatic test_curve_corners();
    logic [ece_pkg::TIME_W-1:0] pts[$];
    pts = '{17'h00001, 17'h00002, 17'h00003, 17'h00100, 17'h00FFF, 17'h04000,
            17'h08000, 17'h0AAAA, 17'h05555, 17'h0C000, 17'h0F000, 17'h0FFFE,
            17'h0FFFF};
    foreach (pts[i]) send_time(pts[i]);
  endtask

  task automatic test_random_times(input int count);
    repeat (count) send_time(random_time());
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    repeat (count) send_time(random_time());
    no_idle = 1'b0;
  endtask

  // Hold the output off long enough for the pipeline to fill and stall the input.
  task automatic test_output_stall(input int count);
    no_idle = 1'b1;
    hold_req <= 1'b1;
    repeat (count) send_time(random_time());
    no_idle = 1'b0;
  endtask

  task automatic drain_results();
    time_ch.valid <= 1'b0;
    while (eased_due_q.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 20) @(posedge clk);
  endtask

  initial begin
    time_ch.valid   <= 1'b0;
    time_ch.time_in <= '0;
    reset_block();
    test_end_points();
    test_curve_corners();
    test_random_times(700);
    test_back_to_back(400);
    test_output_stall(250);
    test_random_times(500);
    drain_results();
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
